// ===== rtl/mdfe_pkg.sv =====
// shared types, marker constants and match-length functions for the frame extractor
`default_nettype none
package mdfe_pkg;

  localparam int MARKER_LEN = 12;
  localparam int MARK_CAP   = 16;
  localparam int HELD_DEPTH = MARKER_LEN - 1;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_ABORT    = 2'd2;

  localparam logic [7:0] START_MARKER [MARK_CAP] = '{
    8'h46, 8'h30, 8'h42, 8'h43, 8'h32, 8'h30, 8'h46, 8'h44,
    8'h35, 8'h39, 8'h42, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00 };
  localparam logic [7:0] END_MARKER [MARK_CAP] = '{
    8'h31, 8'h44, 8'h37, 8'h33, 8'h44, 8'h46, 8'h30, 8'h32,
    8'h41, 8'h36, 8'h34, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00 };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] payload_byte;
  } out_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  function automatic logic [7:0] marker_at(logic is_end, int idx);
    return is_end ? END_MARKER[idx] : START_MARKER[idx];
  endfunction

  // row len, bit k-1: a match of length k may follow a match of length len
  // if the next byte equals marker byte k-1
  function automatic logic [MARK_CAP-1:0][MARK_CAP-1:0] border_table(logic is_end);
    logic [MARK_CAP-1:0][MARK_CAP-1:0] t;
    logic ok;
    t = '0;
    for (int len = 0; len < MARK_CAP; len++) begin
      for (int k = 1; k <= MARK_CAP; k++) begin
        ok = (k <= len + 1);
        if (ok) begin
          for (int i = 0; i < k - 1; i++) begin
            if (marker_at(is_end, i) != marker_at(is_end, len + 1 - k + i)) ok = 1'b0;
          end
        end
        t[len][k-1] = ok;
      end
    end
    return t;
  endfunction

  localparam logic [MARK_CAP-1:0][MARK_CAP-1:0] START_BORDER = border_table(1'b0);
  localparam logic [MARK_CAP-1:0][MARK_CAP-1:0] END_BORDER   = border_table(1'b1);

  function automatic logic [4:0] match_next(logic is_end, logic [3:0] len, logic [7:0] b);
    logic [MARK_CAP-1:0] row;
    logic [4:0] res;
    row = is_end ? END_BORDER[len] : START_BORDER[len];
    res = '0;
    for (int k = 1; k <= MARK_CAP; k++) begin
      if (row[k-1] && (marker_at(is_end, k - 1) == b)) res = 5'(k);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mdfe_cell.sv =====
// one stage of the payload delay line
`default_nettype none
module mdfe_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mdfe_pkg::cell_ctl_t ctl,
  input  wire logic [7:0]        nbr_byte,
  input  wire logic              nbr_valid,
  output logic      [7:0]        held_byte,
  output logic                   held_valid
);
  import mdfe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (ctl.clear) begin
      held_valid <= 1'b0;
    end else if (ctl.shift) begin
      held_valid <= nbr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      held_byte <= nbr_byte;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mdfe_out_queue.sv =====
// small result queue taking up to two results per beat
`default_nettype none
module mdfe_out_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [1:0]    push_count,
  input  wire mdfe_pkg::out_t push0,
  input  wire mdfe_pkg::out_t push1,
  output logic               room,
  output logic               out_valid,
  input  wire logic          out_stall,
  output mdfe_pkg::out_t     out_data
);
  import mdfe_pkg::*;

  out_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign out_valid = (count != '0);
  assign out_data  = q[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // two free places are needed for the worst beat
  assign room      = (count <= QCNT_W'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_count);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(push_count) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) q[wr_ptr] <= push0;
    if (push_count == 2'd2) q[wr_ptr + 1'b1] <= push1;
  end

endmodule
`default_nettype wire

// ===== rtl/marker_delimited_frame_extractor.sv =====
// top level: marker hunting, frame control, delay line and result queue
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_t  (data_byte, end_of_buffer)
//  out     | output    | out_valid/out_stall| out_t (result_kind, payload_byte)
//
// one input beat per cycle while in_stall is low; marker matching is one table lookup per byte
// the delay line shifts one cell per accepted payload byte
// a buffer end inside a frame gives up to two results, drained by the queue one per cycle while out_stall is low
// in_stall rises only while the queue has fewer than two free places
// synchronous reset clears match state, cell valid bits and the queue
`default_nettype none
module marker_delimited_frame_extractor (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire mdfe_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output mdfe_pkg::out_t      out_data
);
  import mdfe_pkg::*;

  localparam logic [4:0] MLEN = 5'(MARKER_LEN);

  logic       in_frame, in_frame_next;
  logic [3:0] start_len, start_len_next;
  logic [3:0] end_len, end_len_next;
  logic       accept;
  logic       room;
  logic [4:0] start_m, end_m;
  cell_ctl_t  ctl;
  logic [1:0] push_count;
  out_t       push0, push1;

  logic [7:0] chain_byte  [HELD_DEPTH+1];
  logic       chain_valid [HELD_DEPTH+1];

  assign in_stall = !room;
  assign accept   = in_valid && room;
  assign start_m  = match_next(1'b0, start_len, in_data.data_byte);
  assign end_m    = match_next(1'b1, end_len, in_data.data_byte);

  assign chain_byte[HELD_DEPTH]  = in_data.data_byte;
  assign chain_valid[HELD_DEPTH] = 1'b1;

  for (genvar i = 0; i < HELD_DEPTH; i++) begin : g_cell
    mdfe_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .nbr_byte   (chain_byte[i+1]),
      .nbr_valid  (chain_valid[i+1]),
      .held_byte  (chain_byte[i]),
      .held_valid (chain_valid[i])
    );
  end

  always_comb begin
    in_frame_next  = in_frame;
    start_len_next = start_len;
    end_len_next   = end_len;
    ctl            = '0;
    push_count     = 2'd0;
    push0          = '{result_kind: KIND_PAYLOAD, payload_byte: chain_byte[0]};
    push1          = '{result_kind: KIND_ABORT, payload_byte: 8'h00};
    if (accept) begin
      if (!in_frame) begin
        if (start_m >= MLEN) begin
          in_frame_next  = 1'b1;
          start_len_next = '0;
          end_len_next   = '0;
          ctl.clear      = 1'b1;
        end else begin
          start_len_next = start_m[3:0];
        end
      end else begin
        if (end_m >= MLEN) begin
          push0          = '{result_kind: KIND_COMPLETE, payload_byte: 8'h00};
          push_count     = 2'd1;
          in_frame_next  = 1'b0;
          start_len_next = '0;
          end_len_next   = '0;
          ctl.clear      = 1'b1;
        end else begin
          end_len_next = end_m[3:0];
          ctl.shift    = 1'b1;
          // oldest byte leaves once the line is full
          if (chain_valid[0]) push_count = 2'd1;
        end
      end
      if (in_data.end_of_buffer) begin
        if (in_frame_next) begin
          if (push_count == 2'd0) begin
            push0      = '{result_kind: KIND_ABORT, payload_byte: 8'h00};
            push_count = 2'd1;
          end else begin
            push_count = 2'd2;
          end
        end
        in_frame_next  = 1'b0;
        start_len_next = '0;
        end_len_next   = '0;
        ctl.clear      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      start_len <= '0;
      end_len   <= '0;
    end else begin
      in_frame  <= in_frame_next;
      start_len <= start_len_next;
      end_len   <= end_len_next;
    end
  end

  mdfe_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (push0),
    .push1      (push1),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
